### sv/tas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tas_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_ENABLE = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_BASE   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_LIMIT  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_PITCH  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SPARE  = 3'd4;

  localparam int unsigned PitchW = 16;
  localparam int unsigned UnitW  = 8;   // pitch in 256-byte units
  localparam int unsigned DivStep = 4;  // quotient bits per divider stage
  localparam int unsigned LowW   = 12;  // bits below the 4 KiB unit

  // chunk rotation per 1 KiB group
  localparam logic [1:0] ROT_TAB [4] = '{2'd0, 2'd2, 2'd3, 2'd1};

  typedef struct packed {
    logic valid;
    logic hit;
  } tas_ctl_t;

endpackage

`default_nettype wire

### sv/tas_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tas_front #(
  parameter int unsigned ADDR_BITS = 27
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     accept_i,
  input  wire logic [ADDR_BITS-1:0]     addr_i,
  input  wire logic                     enable_i,
  input  wire logic [ADDR_BITS-1:0]     base_i,
  input  wire logic [ADDR_BITS-1:0]     limit_i,
  input  wire logic [tas_pkg::PitchW-1:0] pitch_i,
  input  wire logic [tas_pkg::PitchW-1:0] spare_i,
  output tas_pkg::tas_ctl_t             ctl_o,
  output logic [ADDR_BITS-1:0]          offset_o,
  output logic [tas_pkg::UnitW-1:0]     units_o
);
  import tas_pkg::*;

  logic               in_win;
  logic               wp_ok;
  logic               sp_ok;
  tas_ctl_t           ctl_d, ctl_q;
  logic [UnitW-1:0]   units_d, units_q;
  logic [ADDR_BITS-1:0] offset_d, offset_q;

  always_comb begin
    in_win   = enable_i && (addr_i >= base_i) && (addr_i <= limit_i);
    wp_ok    = (pitch_i[7:0] == 8'd0) && (pitch_i[15:8] != 8'd0);
    sp_ok    = (spare_i[7:0] == 8'd0) && (spare_i[15:8] != 8'd0);
    units_d  = wp_ok ? pitch_i[15:8] : spare_i[15:8];
    offset_d = addr_i - base_i;
    ctl_d.valid = accept_i;
    ctl_d.hit   = accept_i && in_win && (wp_ok || sp_ok);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    units_q  <= units_d;
    offset_q <= offset_d;
  end

  assign ctl_o    = ctl_q;
  assign offset_o = offset_q;
  assign units_o  = units_q;

endmodule

`default_nettype wire

### sv/tas_div_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module tas_div_stage #(
  parameter int unsigned QW = 20
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire tas_pkg::tas_ctl_t        ctl_i,
  input  wire logic [tas_pkg::UnitW-1:0] units_i,
  input  wire logic [QW-1:0]            num_i,
  input  wire logic [tas_pkg::UnitW-1:0] rem_i,
  input  wire logic [7:0]               low_i,
  output tas_pkg::tas_ctl_t             ctl_o,
  output logic [tas_pkg::UnitW-1:0]     units_o,
  output logic [QW-1:0]                 num_o,
  output logic [tas_pkg::UnitW-1:0]     rem_o,
  output logic [7:0]                    low_o
);
  import tas_pkg::*;

  logic [UnitW:0]   r;
  logic [QW-1:0]    n;
  tas_ctl_t         ctl_q;
  logic [UnitW-1:0] units_q;
  logic [QW-1:0]    num_q;
  logic [UnitW-1:0] rem_q;
  logic [7:0]       low_q;

  // restoring division, dividend bits shift out the top of n, quotient in at the bottom
  always_comb begin
    r = {1'b0, rem_i};
    n = num_i;
    for (int k = 0; k < DivStep; k++) begin
      r = {r[UnitW-1:0], n[QW-1]};
      n = {n[QW-2:0], 1'b0};
      if (r >= {1'b0, units_i}) begin
        r    = r - {1'b0, units_i};
        n[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    units_q <= units_i;
    num_q   <= n;
    rem_q   <= r[UnitW-1:0];
    low_q   <= low_i;
  end

  assign ctl_o   = ctl_q;
  assign units_o = units_q;
  assign num_o   = num_q;
  assign rem_o   = rem_q;
  assign low_o   = low_q;

  // partial remainder stays below the divisor on a hit
  a_rem_below_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q.valid && ctl_q.hit |-> rem_q < units_q)
    else $error("partial remainder not below divisor");

endmodule

`default_nettype wire

### sv/tas_assemble.sv
`timescale 1ns / 1ps
`default_nettype none

module tas_assemble #(
  parameter int unsigned ADDR_BITS = 27,
  parameter int unsigned QW        = 20
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire tas_pkg::tas_ctl_t        ctl_i,
  input  wire logic [tas_pkg::UnitW-1:0] units_i,
  input  wire logic [QW-1:0]            row_i,
  input  wire logic [tas_pkg::UnitW-1:0] rem_i,
  input  wire logic [7:0]               low_i,
  input  wire logic [ADDR_BITS-1:0]     base_i,
  output logic                          done_o,
  output logic                          hit_o,
  output logic [ADDR_BITS-1:0]          tiled_o
);
  import tas_pkg::*;

  localparam int unsigned PW = QW + 4;   // band * units
  localparam int unsigned SW = PW + 1;   // plus unit index
  localparam int unsigned TW = SW + LowW;

  logic [1:0]       group;
  logic [1:0]       chunk;
  logic [PW-1:0]    prod_d, prod_q;
  logic [UnitW-1:0] unit_d, unit_q;
  logic [LowW-1:0]  lowpart_d, lowpart_q;
  tas_ctl_t         ctl_q;
  logic [SW-1:0]    sum;
  logic [TW-1:0]    toff;
  logic [ADDR_BITS-1:0] tiled;
  logic             done_q, hit_q;
  logic [ADDR_BITS-1:0] addr_q;

  // stage a: band times units, field split
  always_comb begin
    group     = row_i[3:2];
    chunk     = low_i[5:4] - ROT_TAB[group];
    prod_d    = PW'(row_i[QW-1:4]) * PW'(units_i);
    unit_d    = rem_i ^ {{(UnitW-1){1'b0}}, ~row_i[4]};
    lowpart_d = {group, low_i[7:6], row_i[1:0], chunk, low_i[3:0]};
  end

  // stage b: unit offset, low fields, rebase
  always_comb begin
    sum   = SW'(prod_q) + SW'(unit_q);
    toff  = {sum, lowpart_q};
    tiled = base_i + toff[ADDR_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q  <= '0;
      done_q <= 1'b0;
      hit_q  <= 1'b0;
    end else begin
      ctl_q  <= ctl_i;
      done_q <= ctl_q.valid;
      hit_q  <= ctl_q.valid && ctl_q.hit;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q    <= prod_d;
    unit_q    <= unit_d;
    lowpart_q <= lowpart_d;
    addr_q    <= ctl_q.hit ? tiled : '0;
  end

  assign done_o  = done_q;
  assign hit_o   = hit_q;
  assign tiled_o = addr_q;

  // a miss always carries a zero address
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && !hit_q |-> addr_q == '0)
    else $error("miss result with nonzero address");

  // hit is only raised together with the strobe
  a_hit_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_q |-> done_q)
    else $error("hit without result strobe");

endmodule

`default_nettype wire

### sv/tiled_address_swizzle.sv
// channel   | direction | ports                                      | handshake
// ----------+-----------+--------------------------------------------+---------------------------
// command   | in        | start, busy, lin_address_i                 | beat when start && !busy
// result    | out       | done_o, hit_o, tiled_address_o             | beat when done_o, no stall
// config    | in        | cfg_valid_i, cfg_ready_o, cfg_index_i,     | beat when valid && ready
//           |           | cfg_data_i                                 |
//
// one address enters every cycle; busy stays low, the pipeline never backs up
// an address passes the front stage, then the divider stages that resolve four row
// bits each, then assemble stages a and b, which register the result on done_o
// reset clears the valid bits of every stage and the config registers to zero
// the receiver cannot stall: each result shows for exactly one cycle on done_o
`timescale 1ns / 1ps
`default_nettype none

module tiled_address_swizzle #(
  parameter int unsigned ADDR_BITS = 27
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // command beat
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [ADDR_BITS-1:0]          lin_address_i,
  // result beat
  output logic                               done_o,
  output logic                               hit_o,
  output logic [ADDR_BITS-1:0]               tiled_address_o,
  // config write beat
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [tas_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [ADDR_BITS-1:0]          cfg_data_i
);
  import tas_pkg::*;

  // row = (offset >> 8) / units, padded up to whole divider stages
  localparam int unsigned QBITS   = ADDR_BITS - 8;
  localparam int unsigned NSTAGES = (QBITS + DivStep - 1) / DivStep;
  localparam int unsigned QW      = NSTAGES * DivStep;
  localparam int unsigned LAT     = NSTAGES + 3;

  // config registers
  logic                 window_enable_q;
  logic [ADDR_BITS-1:0] window_base_q;
  logic [ADDR_BITS-1:0] window_limit_q;
  logic [PitchW-1:0]    window_pitch_q;
  logic [PitchW-1:0]    spare_pitch_q;
  logic                 cfg_we;
  logic                 accept;

  // front stage outputs
  tas_ctl_t             front_ctl;
  logic [ADDR_BITS-1:0] front_offset;
  logic [UnitW-1:0]     front_units;

  // divider chain, index 0 feeds the first stage
  tas_ctl_t             ctl_s   [NSTAGES+1];
  logic [UnitW-1:0]     units_s [NSTAGES+1];
  logic [QW-1:0]        num_s   [NSTAGES+1];
  logic [UnitW-1:0]     rem_s   [NSTAGES+1];
  logic [7:0]           low_s   [NSTAGES+1];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // register file, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_enable_q <= 1'b0;
      window_base_q   <= '0;
      window_limit_q  <= '0;
      window_pitch_q  <= '0;
      spare_pitch_q   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        REG_ENABLE: window_enable_q <= cfg_data_i[0];
        REG_BASE:   window_base_q   <= cfg_data_i;
        REG_LIMIT:  window_limit_q  <= cfg_data_i;
        REG_PITCH:  window_pitch_q  <= cfg_data_i[PitchW-1:0];
        REG_SPARE:  spare_pitch_q   <= cfg_data_i[PitchW-1:0];
        default: ;
      endcase
    end
  end

  // window check, pitch pick, offset from base
  tas_front #(
    .ADDR_BITS(ADDR_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .addr_i  (lin_address_i),
    .enable_i(window_enable_q),
    .base_i  (window_base_q),
    .limit_i (window_limit_q),
    .pitch_i (window_pitch_q),
    .spare_i (spare_pitch_q),
    .ctl_o   (front_ctl),
    .offset_o(front_offset),
    .units_o (front_units)
  );

  // the low byte of the offset bypasses the divider: pitch is a multiple of 256
  assign ctl_s[0]   = front_ctl;
  assign units_s[0] = front_units;
  assign num_s[0]   = QW'(front_offset[ADDR_BITS-1:8]);
  assign rem_s[0]   = '0;
  assign low_s[0]   = front_offset[7:0];

  for (genvar g = 0; g < NSTAGES; g++) begin : g_div
    tas_div_stage #(
      .QW(QW)
    ) u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_s[g]),
      .units_i(units_s[g]),
      .num_i  (num_s[g]),
      .rem_i  (rem_s[g]),
      .low_i  (low_s[g]),
      .ctl_o  (ctl_s[g+1]),
      .units_o(units_s[g+1]),
      .num_o  (num_s[g+1]),
      .rem_o  (rem_s[g+1]),
      .low_o  (low_s[g+1])
    );
  end

  // after the last stage num holds the row and rem the 256-byte column
  tas_assemble #(
    .ADDR_BITS(ADDR_BITS),
    .QW       (QW)
  ) u_assemble (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_s[NSTAGES]),
    .units_i(units_s[NSTAGES]),
    .row_i  (num_s[NSTAGES]),
    .rem_i  (rem_s[NSTAGES]),
    .low_i  (low_s[NSTAGES]),
    .base_i (window_base_q),
    .done_o (done_o),
    .hit_o  (hit_o),
    .tiled_o(tiled_address_o)
  );

  // every accepted beat comes out after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT done_o)
    else $error("result beat missing after pipeline latency");

endmodule

`default_nettype wire
